// ===== src/itra_pkg.sv =====
// Shared types, codes and helpers of the integer-to-radix ASCII formatter.
// Used by the digit cells, the core and the testbench; no dependencies.
package itra_pkg;

    // Radix selector as it arrives in the input beat; the fourth code maps to decimal.
    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_OCT = 2'd2,
        RADIX_RSV = 2'd3
    } t_radix;

    // Commands that the core sends to every cell of the digit chain.
    typedef struct packed {
        logic clear;    // load zero into the digit
        logic convert;  // double the digit and add the carry from below
        logic shift;    // take the digit of the lower neighbor
    } t_cell_ctl;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOWER = 8'h61;
    localparam logic [7:0] CHAR_UPPER = 8'h41;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    // ASCII character of one digit value.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] base;
        if (d < 4'd10) begin
            digit_char = CHAR_ZERO + {4'd0, d};
        end else begin
            base = upper ? CHAR_UPPER : CHAR_LOWER;
            digit_char = base + {4'd0, d} - 8'd10;
        end
    endfunction

endpackage

// ===== src/itra_cell.sv =====
// One digit cell of the conversion chain: holds a single digit of the result.
// Depends on itra_pkg for the radix code and the cell command struct.
module itra_cell (
    input  logic               i_clk,
    input  itra_pkg::t_cell_ctl i_ctl,
    input  itra_pkg::t_radix   i_radix,
    input  logic               i_carry,
    input  logic [3:0]         i_digit,
    output logic               o_carry,
    output logic [3:0]         o_digit
);
    import itra_pkg::*;

    logic [3:0] r_digit;
    logic [3:0] n_digit;
    logic [3:0] w_half;
    logic [4:0] w_radix;
    logic [4:0] w_sum;
    logic [4:0] w_diff;

    always_comb begin
        unique case (i_radix)
            RADIX_HEX: begin
                w_half  = 4'd8;
                w_radix = 5'd16;
            end
            RADIX_OCT: begin
                w_half  = 4'd4;
                w_radix = 5'd8;
            end
            default: begin
                w_half  = 4'd5;
                w_radix = 5'd10;
            end
        endcase
    end

    // 2*d + c reaches the radix exactly when d reaches half of it, so the
    // carry out depends on this cell alone and does not ripple down the chain.
    assign o_carry = (r_digit >= w_half);
    assign o_digit = r_digit;
    assign w_sum   = {r_digit, i_carry};
    assign w_diff  = o_carry ? (w_sum - w_radix) : w_sum;

    always_comb begin
        n_digit = r_digit;
        if (i_ctl.clear) begin
            n_digit = 4'd0;
        end else if (i_ctl.convert) begin
            n_digit = w_diff[3:0];
        end else if (i_ctl.shift) begin
            n_digit = i_digit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_digit <= n_digit;
    end

endmodule

// ===== src/integer_to_radix_ascii_core.sv =====
// Bit-serial conversion feeds the magnitude into the digit chain, most significant bit
// first; then an optional sign goes out, and the chain shifts once per digit position as
// leading zeros shift out unseen. No new number is taken until the last character has
// been loaded and the sequencer is back in idle; output stalls hold the sign and digits.
// Reset (i_rst_n low at a clock edge) empties the output register, returns the sequencer
// to idle and selects lower-case hex letters.
module integer_to_radix_ascii_core #(
    parameter int VALUE_WIDTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration: bit 0 selects upper-case hex letters.
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    // Input beats.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [63:0] value
    input  logic [2:0]  i_s_tuser,   // [1:0] radix_code, [2] is_signed
    // Output beats, one character each.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [7:0]  o_m_tdata,   // [7:0] out_char
    output logic        o_m_tlast    // is_last
);
    import itra_pkg::*;

    // Octal needs the most digits of the three radices for any width.
    localparam int NUM_CELLS = (VALUE_WIDTH + 2) / 3;
    localparam int CNT_W     = $clog2(VALUE_WIDTH + 1);
    localparam int POS_W     = $clog2(NUM_CELLS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_EMIT
    } t_state;

    t_state                 r_state;
    logic [VALUE_WIDTH-1:0] r_bits;
    logic [CNT_W-1:0]       r_cnt;
    logic [POS_W-1:0]       r_pos;
    logic                   r_started;
    logic                   r_has_sign;
    logic                   r_negative;
    t_radix                 r_radix;
    logic                   r_hex_upper;
    logic                   r_out_valid;
    logic [7:0]             r_out_char;
    logic                   r_out_last;

    logic                   w_accept;
    logic                   w_out_free;
    logic                   w_load;
    logic [VALUE_WIDTH-1:0] w_value;
    logic                   w_neg;
    logic [VALUE_WIDTH-1:0] w_mag;
    t_radix                 w_radix_in;
    logic [3:0]             w_top;
    logic                   w_skip;
    logic                   w_emit;
    t_cell_ctl              w_ctl;
    logic [3:0]             w_digit [NUM_CELLS];
    logic                   w_carry [NUM_CELLS];

    // No beat is taken while reset is held.
    assign o_s_tready = (r_state == ST_IDLE) && i_rst_n;
    assign w_accept   = i_s_tvalid && o_s_tready;
    // The output register takes a new character when it is empty or being drained.
    assign w_out_free = !r_out_valid || i_m_tready;

    // Input decode: bits above the configured width are ignored, and a negative
    // signed number is turned into its magnitude (the most negative value comes
    // out as 2^(VALUE_WIDTH-1), which the unsigned vector holds exactly).
    assign w_value    = i_s_tdata[VALUE_WIDTH-1:0];
    assign w_neg      = i_s_tuser[2] && w_value[VALUE_WIDTH-1];
    assign w_mag      = w_neg ? (~w_value + {{(VALUE_WIDTH-1){1'b0}}, 1'b1}) : w_value;
    assign w_radix_in = (t_radix'(i_s_tuser[1:0]) == RADIX_RSV) ? RADIX_DEC
                                                                : t_radix'(i_s_tuser[1:0]);

    // Digits sit least significant in cell 0; the chain shifts upward while
    // characters are taken from the top cell. Leading zeros are shifted out
    // unseen, but the final position is always shown so that zero gives "0".
    assign w_top  = w_digit[NUM_CELLS-1];
    assign w_skip = (r_state == ST_EMIT) && !r_started && (w_top == 4'd0)
                    && (r_pos > POS_W'(1));
    assign w_emit = (r_state == ST_EMIT) && !w_skip && w_out_free;
    // A sign or a digit enters the output register in this cycle.
    assign w_load = ((r_state == ST_SIGN) && w_out_free) || w_emit;

    always_comb begin
        w_ctl.clear   = w_accept;
        w_ctl.convert = (r_state == ST_CONVERT);
        w_ctl.shift   = w_skip || w_emit;
    end

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        logic       w_cin;
        logic [3:0] w_din;
        if (g == 0) begin : g_first
            assign w_cin = r_bits[VALUE_WIDTH-1];
            assign w_din = 4'd0;
        end else begin : g_next
            assign w_cin = w_carry[g-1];
            assign w_din = w_digit[g-1];
        end
        itra_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_radix (r_radix),
            .i_carry (w_cin),
            .i_digit (w_din),
            .o_carry (w_carry[g]),
            .o_digit (w_digit[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_hex_upper <= 1'b0;
            r_started   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_hex_upper <= i_cfg_wdata;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_bits     <= w_mag;
                        r_radix    <= w_radix_in;
                        r_negative <= w_neg;
                        r_has_sign <= i_s_tuser[2] && (w_value != '0);
                        r_cnt      <= CNT_W'(VALUE_WIDTH);
                        r_state    <= ST_CONVERT;
                    end
                end
                ST_CONVERT: begin
                    // Feed the magnitude into the chain, most significant bit first.
                    r_bits    <= {r_bits[VALUE_WIDTH-2:0], 1'b0};
                    r_cnt     <= r_cnt - CNT_W'(1);
                    r_pos     <= POS_W'(NUM_CELLS);
                    r_started <= 1'b0;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= r_has_sign ? ST_SIGN : ST_EMIT;
                    end
                end
                ST_SIGN: begin
                    if (w_out_free) begin
                        r_out_char  <= r_negative ? CHAR_MINUS : CHAR_PLUS;
                        r_out_last  <= 1'b0;
                        r_state     <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (w_skip || w_emit) begin
                        r_pos <= r_pos - POS_W'(1);
                    end
                    if (w_emit) begin
                        r_started   <= 1'b1;
                        r_out_char  <= digit_char(w_top, r_hex_upper);
                        r_out_last  <= (r_pos == POS_W'(1));
                        if (r_pos == POS_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_char;
    assign o_m_tlast  = r_out_last;

endmodule

// ===== src/itra_checker.sv =====
// Port-level checker for integer_to_radix_ascii_core, attached by the bind below.
// Depends only on the core's ports; no package needed.
module itra_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic       o_m_tlast
);

    // A waiting character beat holds its payload until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tlast)))
        else $error("output beat changed while stalled");

    // Once a number is accepted, no other can enter while it is being converted.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready ##1 !o_s_tready)
        else $error("input accepted during conversion");

    // Every character is a digit, a hex letter or a sign.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata >= 8'h30 && o_m_tdata <= 8'h39) ||
                        (o_m_tdata >= 8'h41 && o_m_tdata <= 8'h46) ||
                        (o_m_tdata >= 8'h61 && o_m_tdata <= 8'h66) ||
                        o_m_tdata == 8'h2B || o_m_tdata == 8'h2D))
        else $error("output character outside the digit set");

    // A sign is never the final character of a number.
    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata == 8'h2B || o_m_tdata == 8'h2D)) |-> !o_m_tlast)
        else $error("sign character marked last");

endmodule

bind integer_to_radix_ascii_core itra_checker u_itra_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// ===== tb/tb.sv =====
// Self-checking testbench for integer_to_radix_ascii_core: directed and random numbers in
// all radices, both hex letter cases, random stalls on both stream sides.
// Depends on src/itra_pkg.sv and src/integer_to_radix_ascii_core.sv.
module tb;
    import itra_pkg::*;

    localparam int          VALUE_WIDTH = 64;
    localparam logic [63:0] VALUE_MASK  = (VALUE_WIDTH >= 64) ? {64{1'b1}}
                                        : ((64'd1 << VALUE_WIDTH) - 64'd1);
    // Watchdog bound on the length of a full run.
    localparam int          CYCLE_LIMIT = 1000000;
    // Settle time after the drain, long enough for the core to send one late number.
    localparam int          SETTLE_CYCLES = 120;
    localparam int          MAX_REPORTS = 10;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_UPPER = 8'h41;
    localparam logic [7:0] ASCII_LOWER = 8'h61;
    localparam logic [7:0] ASCII_PLUS  = 8'h2B;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    // One output character together with its end-of-number mark.
    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_char_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [63:0] i_s_tdata;   // [63:0] value
    logic [2:0]  i_s_tuser;   // [1:0] radix_code, [2] is_signed
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [7:0]  o_m_tdata;   // [7:0] out_char
    logic        o_m_tlast;   // is_last

    // Characters still owed by the core, oldest first.
    t_char_beat  expected_text[$];
    // Our own copy of the hex letter case register.
    logic        hex_upper_model = 1'b0;
    int unsigned fail_count = 0;
    int unsigned cycle_count = 0;
    // Random idling on the input side and on the output side.
    logic        src_idle_en = 1'b0;
    logic        sink_idle_en = 1'b0;
    int unsigned sink_stall_left = 0;

    integer_to_radix_ascii_core #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Watchdog: a hung handshake or a lost character ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("integer_to_radix_ascii_core regression: fail");
            $finish;
        end
    end

    // Output side back-pressure: while enabled, stalls of a randomly drawn length start at
    // random, with ready high in between.
    always @(posedge i_clk) begin
        if (sink_stall_left != 0) begin
            sink_stall_left <= sink_stall_left - 1;
            i_m_tready <= (sink_stall_left == 1);
        end else if (sink_idle_en && $urandom_range(0, 5) == 0) begin
            sink_stall_left <= $urandom_range(1, 9);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // Formats one number the way the core must: an optional sign, then the digits of the
    // magnitude with no leading zeros. The characters are queued, the last one marked.
    function automatic void predict_text(input logic [63:0] raw, input t_radix radix,
                                         input logic signd, input logic upper);
        logic [63:0] mag;
        logic [63:0] base;
        logic [3:0]  d;
        logic [7:0]  ch;
        logic [7:0]  text[$];
        int          first_digit;
        mag = raw & VALUE_MASK;
        case (radix)
            RADIX_HEX: base = 64'd16;
            RADIX_OCT: base = 64'd8;
            default:   base = 64'd10;   // the reserved code reads as decimal
        endcase
        if (signd && mag != 64'd0) begin
            if (mag[VALUE_WIDTH-1]) begin
                text.push_back(ASCII_MINUS);
                // The most negative value negates to itself, which is its true magnitude.
                mag = (~mag + 64'd1) & VALUE_MASK;
            end else begin
                text.push_back(ASCII_PLUS);
            end
        end
        first_digit = text.size();
        // Digits come out least significant first, so each goes in just after the sign.
        do begin
            d = 4'(mag % base);
            if (d < 4'd10) begin
                ch = ASCII_ZERO + 8'(d);
            end else begin
                ch = (upper ? ASCII_UPPER : ASCII_LOWER) + 8'(d) - 8'd10;
            end
            text.insert(first_digit, ch);
            mag = mag / base;
        end while (mag != 64'd0);
        foreach (text[i]) begin
            expected_text.push_back({text[i], i == text.size() - 1});
        end
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("t=%0t mismatch: %s", $realtime, what);
        end
    endtask

    // Port monitor: predicts on every accepted input beat and checks every accepted
    // output beat against the oldest character owed. Only pre-edge values are read here.
    always @(posedge i_clk) begin : watch_ports
        t_char_beat want;
        if (!i_rst_n) begin
            hex_upper_model = 1'b0;
        end else begin
            if (i_cfg_we) begin
                hex_upper_model = i_cfg_wdata;
            end
            if (i_s_tvalid && o_s_tready) begin
                predict_text(i_s_tdata, t_radix'(i_s_tuser[1:0]), i_s_tuser[2],
                             hex_upper_model);
            end
            if (o_m_tvalid && i_m_tready) begin
                if (expected_text.size() == 0) begin
                    note_failure($sformatf("unexpected char 0x%02h last=%0b",
                                           o_m_tdata, o_m_tlast));
                end else begin
                    want = expected_text.pop_front();
                    if (o_m_tdata !== want.ch || o_m_tlast !== want.last) begin
                        note_failure($sformatf("char expected 0x%02h last=%0b, got 0x%02h last=%0b",
                                               want.ch, want.last, o_m_tdata, o_m_tlast));
                    end
                end
            end
        end
    end

    // Presents one number and returns at the edge where the core takes it. The valid
    // stays high afterwards so that back-to-back numbers need no extra assignment.
    task automatic send_number(input logic [63:0] value, input t_radix radix,
                               input logic signd);
        int unsigned gap;
        if (src_idle_en && $urandom_range(0, 2) == 0) begin
            gap = $urandom_range(1, 9);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= value;
        i_s_tuser  <= {signd, radix};
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    // Stops sending and waits until every owed character has come out, so the core is idle.
    task automatic drain_output();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_text.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // The register is only written with the core idle.
    task automatic set_hex_case(input logic upper);
        drain_output();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= upper;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Extremes in every radix with the reset letter case: zero with and without sign,
    // all ones, the most negative and most positive signed values, the reserved radix.
    task automatic test_directed_lower_case();
        send_number(64'd0, RADIX_DEC, 1'b0);
        send_number(64'd0, RADIX_HEX, 1'b0);
        send_number(64'd0, RADIX_OCT, 1'b0);
        send_number(64'd0, RADIX_DEC, 1'b1);
        send_number({64{1'b1}}, RADIX_DEC, 1'b0);
        send_number({64{1'b1}}, RADIX_HEX, 1'b0);
        send_number({64{1'b1}}, RADIX_OCT, 1'b0);
        send_number({64{1'b1}}, RADIX_DEC, 1'b1);
        // The most negative value: octal gives the longest text, a sign and 22 digits.
        send_number({1'b1, 63'd0}, RADIX_DEC, 1'b1);
        send_number({1'b1, 63'd0}, RADIX_HEX, 1'b1);
        send_number({1'b1, 63'd0}, RADIX_OCT, 1'b1);
        send_number({1'b0, {63{1'b1}}}, RADIX_DEC, 1'b1);
        send_number(64'd1, RADIX_HEX, 1'b1);
        send_number(64'd8, RADIX_OCT, 1'b0);
        send_number(64'd12345, RADIX_RSV, 1'b0);
        send_number(64'd0 - 64'd907, RADIX_RSV, 1'b1);
        send_number(64'hDEAD_BEEF_CAFE_F00D, RADIX_HEX, 1'b0);
    endtask

    task automatic test_directed_upper_case();
        set_hex_case(1'b1);
        send_number(64'hDEAD_BEEF_CAFE_F00D, RADIX_HEX, 1'b0);
        send_number(64'hFFFF_FFFF_FFFF_FF5A, RADIX_HEX, 1'b1);
        send_number(64'h0ABC_DEF0_1234_5678, RADIX_HEX, 1'b1);
        send_number(64'd255, RADIX_DEC, 1'b0);
    endtask

    // Draws one random number; the mix favors short texts, powers of two and values
    // near the sign boundary over plain 64-bit noise.
    task automatic send_random_number();
        logic [63:0] value;
        case ($urandom_range(0, 6))
            0:       value = {$urandom, $urandom};
            1:       value = 64'($urandom_range(0, 40));
            2:       value = 64'd1 << $urandom_range(0, 63);
            3:       value = (64'd1 << $urandom_range(0, 63)) - 64'd1;
            4:       value = 64'd0 - 64'($urandom_range(0, 40));
            5:       value = {1'b1, 63'd0} + 64'($urandom_range(0, 3)) - 64'd2;
            default: value = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        send_number(value, t_radix'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    endtask

    // Six phases, the first in lower case and the rest with a random letter case, and different idling on each side.
    task automatic test_random_mix();
        for (int phase = 0; phase < 6; phase++) begin
            set_hex_case(phase == 0 ? 1'b0 : 1'($urandom_range(0, 1)));
            src_idle_en  = (phase != 2 && phase != 4);
            sink_idle_en = (phase != 3 && phase != 4);
            repeat (72) send_random_number();
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_quiet_tail();
        set_hex_case(1'b1);
        src_idle_en  = 1'b0;
        sink_idle_en = 1'b0;
        repeat (40) send_random_number();
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_en  = 1'b1;
        sink_idle_en = 1'b1;
        test_directed_lower_case();
        test_directed_upper_case();
        test_random_mix();
        test_quiet_tail();

        drain_output();
        // Anything the core sends after this point is flagged by the monitor.
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("integer_to_radix_ascii_core regression: pass");
        end else begin
            $display("integer_to_radix_ascii_core regression: fail");
        end
        $finish;
    end

endmodule
